// ===== hw/rtl/tesm_pkg.sv =====
`default_nettype none

package tesm_pkg;

   // number of cells in the sorting chain
   localparam int STORE_DEPTH = 64;
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

   localparam int TIME_W    = 32;
   localparam int KIND_W    = 3;
   localparam int CHAN_W    = 4;
   localparam int VEL_W     = 7;
   localparam int PAYLOAD_W = 24;
   localparam int STATUS_W  = 3;
   localparam int CSR_IDX_W = 2;

   // event kinds
   localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 3'd0;
   localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TEMPO    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_END      = 3'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_STORED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FILTERED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMITTED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_END      = 3'd4;

   // command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_EN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOTE_FIX_EN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAN_CLR_EN = 2'd2;

   typedef struct packed {
      logic [TIME_W-1:0]    ev_time;
      logic [KIND_W-1:0]    kind;
      logic [CHAN_W-1:0]    channel;
      logic [VEL_W-1:0]     velocity;
      logic [PAYLOAD_W-1:0] payload;
   } event_type;

   // broadcast to every cell
   typedef struct packed {
      logic      ins;
      logic      pop;
      event_type new_evt;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tesm_cell.sv =====
`default_nettype none

module tesm_cell (
   input  wire                    clock,
   input  tesm_pkg::cell_ctrl_type ctrl,
   input  wire                    occupied,
   input  wire                    prev_after,
   input  tesm_pkg::event_type    prev_evt,
   input  tesm_pkg::event_type    next_evt,
   output tesm_pkg::event_type    evt,
   output logic                   after
);

   tesm_pkg::event_type evt_ff;
   tesm_pkg::event_type evt_in;

   // strict compare keeps equal times in load order
   assign after = !occupied || (evt_ff.ev_time > ctrl.new_evt.ev_time);
   assign evt   = evt_ff;

   always_comb begin
      evt_in = evt_ff;
      priority if (ctrl.pop) begin
         evt_in = next_evt;
      end else if (ctrl.ins && after) begin
         evt_in = prev_after ? prev_evt : ctrl.new_evt;
      end else begin
         evt_in = evt_ff;
      end
   end

   always_ff @(posedge clock) begin
      evt_ff <= evt_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/tesm_chain.sv =====
`default_nettype none

module tesm_chain (
   input  wire                                clock,
   input  tesm_pkg::cell_ctrl_type            ctrl,
   input  wire [tesm_pkg::CNT_W-1:0]          count,
   output tesm_pkg::event_type                head
);

   tesm_pkg::event_type evt_q   [tesm_pkg::STORE_DEPTH];
   logic                after_q [tesm_pkg::STORE_DEPTH];

   for (genvar i = 0; i < tesm_pkg::STORE_DEPTH; i++) begin : g_cell
      tesm_pkg::event_type prev_evt;
      tesm_pkg::event_type next_evt;
      logic                prev_after;
      logic                occupied;

      assign occupied = (tesm_pkg::CNT_W'(i) < count);

      if (i == 0) begin : g_first
         assign prev_after = 1'b0;
         assign prev_evt   = ctrl.new_evt;
      end else begin : g_mid
         assign prev_after = after_q[i-1];
         assign prev_evt   = evt_q[i-1];
      end

      if (i == tesm_pkg::STORE_DEPTH - 1) begin : g_last
         assign next_evt = evt_q[i];
      end else begin : g_inner
         assign next_evt = evt_q[i+1];
      end

      tesm_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (occupied),
         .prev_after (prev_after),
         .prev_evt   (prev_evt),
         .next_evt   (next_evt),
         .evt        (evt_q[i]),
         .after      (after_q[i])
      );
   end

   assign head = evt_q[0];

endmodule

`default_nettype wire

// ===== hw/rtl/timed_event_stable_merge_top.sv =====
`default_nettype none
// the result of a command is registered onto the rsp_ ports in the cycle after start is taken
// throughput: one command per cycle, busy stays low; every cell of the chain compares
//   its stored time with the incoming one and shifts in the same cycle
// reset: occupancy and last emitted time go to zero, all three filter enables go to one;
//   the cell contents are left as they are, only occupied cells are ever read
// the receiver cannot stall: each beat is shown for exactly one cycle on rsp_strobe

module timed_event_stable_merge_top (
   input  wire                                 clock,
   input  wire                                 reset,
   // command channel
   input  wire                                 start,
   output logic                                busy,
   input  wire                                 req_cmd,
   input  wire  [tesm_pkg::KIND_W-1:0]         req_event_kind,
   input  wire  [tesm_pkg::TIME_W-1:0]         req_event_time,
   input  wire  [tesm_pkg::CHAN_W-1:0]         req_event_channel,
   input  wire  [tesm_pkg::VEL_W-1:0]          req_event_velocity,
   input  wire  [tesm_pkg::PAYLOAD_W-1:0]      req_event_payload,
   // result channel
   output logic                                rsp_strobe,
   output logic [tesm_pkg::STATUS_W-1:0]       rsp_status,
   output logic [tesm_pkg::KIND_W-1:0]         rsp_out_kind,
   output logic [tesm_pkg::TIME_W-1:0]         rsp_out_time,
   output logic [tesm_pkg::TIME_W-1:0]         rsp_out_delta,
   output logic [tesm_pkg::CHAN_W-1:0]         rsp_out_channel,
   output logic [tesm_pkg::VEL_W-1:0]          rsp_out_velocity,
   output logic [tesm_pkg::PAYLOAD_W-1:0]      rsp_out_payload,
   output logic                                rsp_last,
   // configuration
   input  wire                                 csr_we,
   input  wire  [tesm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire                                 csr_wdata
);

   // control state
   logic                        filter_en_ff,   filter_en_in;
   logic                        note_fix_en_ff, note_fix_en_in;
   logic                        chan_clr_en_ff, chan_clr_en_in;
   logic [tesm_pkg::CNT_W-1:0]  count_ff,       count_in;
   logic [tesm_pkg::TIME_W-1:0] last_time_ff,   last_time_in;
   logic                        rsp_strobe_ff,  rsp_strobe_in;

   // result payload
   logic [tesm_pkg::STATUS_W-1:0]  rsp_status_ff,   rsp_status_in;
   tesm_pkg::event_type            rsp_evt_ff,      rsp_evt_in;
   logic [tesm_pkg::TIME_W-1:0]    rsp_delta_ff,    rsp_delta_in;
   logic                           rsp_last_ff,     rsp_last_in;

   logic                    accept;
   logic                    is_basic;
   logic                    drop;
   logic                    full;
   logic                    empty;
   tesm_pkg::cell_ctrl_type ctrl;
   tesm_pkg::event_type     head;

   // busy is tied low, so start is always accepted
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // load-side filters
   assign is_basic = (req_event_kind == tesm_pkg::KIND_NOTE_OFF) ||
                     (req_event_kind == tesm_pkg::KIND_NOTE_ON)  ||
                     (req_event_kind == tesm_pkg::KIND_TEMPO);
   // end of track never gets stored, filtered kinds win over a full store
   assign drop  = (req_event_kind == tesm_pkg::KIND_END) || (filter_en_ff && !is_basic);
   assign full  = (count_ff == tesm_pkg::CNT_W'(tesm_pkg::STORE_DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      ctrl                      = '0;
      ctrl.new_evt.ev_time      = req_event_time;
      ctrl.new_evt.kind         = req_event_kind;
      ctrl.new_evt.channel      = req_event_channel;
      ctrl.new_evt.velocity     = req_event_velocity;
      ctrl.new_evt.payload      = req_event_payload;
      // with note fix enabled, a zero-velocity note on becomes note off
      if (note_fix_en_ff && (req_event_kind == tesm_pkg::KIND_NOTE_ON) &&
          (req_event_velocity == '0)) begin
         ctrl.new_evt.kind = tesm_pkg::KIND_NOTE_OFF;
      end
      if (chan_clr_en_ff) begin
         ctrl.new_evt.channel = '0;
      end
      ctrl.ins = accept && (req_cmd == tesm_pkg::CMD_LOAD) && !drop && !full;
      ctrl.pop = accept && (req_cmd == tesm_pkg::CMD_POP) && !empty;
   end

   // sorted row of cells, head holds the earliest event
   tesm_chain u_chain (
      .clock (clock),
      .ctrl  (ctrl),
      .count (count_ff),
      .head  (head)
   );

   // occupancy, batch time and the result beat
   always_comb begin
      count_in      = count_ff;
      last_time_in  = last_time_ff;
      rsp_strobe_in = accept;
      rsp_status_in = tesm_pkg::ST_STORED;
      rsp_evt_in    = '0;
      rsp_delta_in  = '0;
      rsp_last_in   = 1'b0;
      if (accept) begin
         unique case (req_cmd)
            tesm_pkg::CMD_LOAD: begin
               priority if (drop) begin
                  rsp_status_in = tesm_pkg::ST_FILTERED;
               end else if (full) begin
                  rsp_status_in = tesm_pkg::ST_FULL;
               end else begin
                  rsp_status_in = tesm_pkg::ST_STORED;
                  count_in      = count_ff + 1'b1;
               end
            end
            tesm_pkg::CMD_POP: begin
               if (empty) begin
                  // closing end of track, next batch starts at zero
                  rsp_status_in      = tesm_pkg::ST_END;
                  rsp_evt_in.kind    = tesm_pkg::KIND_END;
                  rsp_evt_in.ev_time = last_time_ff;
                  rsp_last_in        = 1'b1;
                  last_time_in       = '0;
               end else begin
                  rsp_status_in = tesm_pkg::ST_EMITTED;
                  rsp_evt_in    = head;
                  // wraps when a later load was earlier than an emitted event
                  rsp_delta_in  = head.ev_time - last_time_ff;
                  last_time_in  = head.ev_time;
                  count_in      = count_ff - 1'b1;
               end
            end
            default: begin
               rsp_status_in = tesm_pkg::ST_STORED;
            end
         endcase
      end
   end

   // configuration writes, unknown indexes are ignored
   always_comb begin
      filter_en_in   = filter_en_ff;
      note_fix_en_in = note_fix_en_ff;
      chan_clr_en_in = chan_clr_en_ff;
      if (csr_we) begin
         unique case (csr_index)
            tesm_pkg::CSR_FILTER_EN:   filter_en_in   = csr_wdata;
            tesm_pkg::CSR_NOTE_FIX_EN: note_fix_en_in = csr_wdata;
            tesm_pkg::CSR_CHAN_CLR_EN: chan_clr_en_in = csr_wdata;
            default: begin
               filter_en_in = filter_en_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_en_ff   <= 1'b1;
         note_fix_en_ff <= 1'b1;
         chan_clr_en_ff <= 1'b1;
         count_ff       <= '0;
         last_time_ff   <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         filter_en_ff   <= filter_en_in;
         note_fix_en_ff <= note_fix_en_in;
         chan_clr_en_ff <= chan_clr_en_in;
         count_ff       <= count_in;
         last_time_ff   <= last_time_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_evt_ff    <= rsp_evt_in;
      rsp_delta_ff  <= rsp_delta_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_kind     = rsp_evt_ff.kind;
   assign rsp_out_time     = rsp_evt_ff.ev_time;
   assign rsp_out_delta    = rsp_delta_ff;
   assign rsp_out_channel  = rsp_evt_ff.channel;
   assign rsp_out_velocity = rsp_evt_ff.velocity;
   assign rsp_out_payload  = rsp_evt_ff.payload;
   assign rsp_last         = rsp_last_ff;

   // occupancy never passes the chain length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tesm_pkg::CNT_W'(tesm_pkg::STORE_DEPTH))
      else $error("occupancy beyond store depth");

   // every accepted command gives exactly one beat on the next cycle
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("missing result beat");

   // the closing beat is marked last with no delta, and only it is
   a_end_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_status == tesm_pkg::ST_END) == rsp_last) &&
                     (!rsp_last || (rsp_out_delta == '0)))
      else $error("bad end of track beat");

endmodule

`default_nettype wire
